// ----- sv/sgb_pkg.sv -----
package sgb_pkg;

	localparam int SAMPLE_W   = 8;
	localparam int TAP_W      = 16;
	localparam int FRAC_W     = 15;
	localparam int ACC_W      = 27;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ROW_W      = 12;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int TAP_CNT_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH,
		CFG_FRAME_HEIGHT,
		CFG_CHANNEL_COUNT,
		CFG_BLUR_RADIUS,
		CFG_TAP_CENTER,
		CFG_TAP_ONE,
		CFG_TAP_TWO,
		CFG_TAP_THREE
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROW,
		S_CHECK,
		S_VERT,
		S_VLAST,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic clr;
		logic en;
	} mac_ctrl_t;

	function automatic logic [SAMPLE_W-1:0] sat8(input logic [ACC_W-1:0] acc);
		logic [ACC_W-FRAC_W-1:0] v;
		v = acc[ACC_W-1:FRAC_W];
		return (|v[ACC_W-FRAC_W-1:SAMPLE_W]) ? {SAMPLE_W{1'b1}} : v[SAMPLE_W-1:0];
	endfunction

endpackage

// ----- sv/sgb_ram.sv -----
module sgb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 7168
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/sgb_mac.sv -----
module sgb_mac #(
	parameter int LANES = 3
) (
	input  logic                                   clk,
	input  sgb_pkg::mac_ctrl_t                     ctrl,
	input  logic [sgb_pkg::TAP_W-1:0]              weight,
	input  logic [LANES-1:0][sgb_pkg::SAMPLE_W-1:0] samples,
	output logic [LANES-1:0][sgb_pkg::SAMPLE_W-1:0] sat
);
	import sgb_pkg::*;

	logic [LANES-1:0][ACC_W-1:0] acc_q;
	logic [LANES-1:0][ACC_W-1:0] acc_sum;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			acc_sum[i] = ctrl.en ? acc_q[i] + ACC_W'(weight) * ACC_W'(samples[i]) : acc_q[i];
			sat[i]     = sat8(acc_sum[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			acc_q[i] <= ctrl.clr ? '0 : acc_sum[i];
		end
	end

endmodule

// ----- sv/separable_gaussian_blur_unit.sv -----
// separable gaussian blur, replicated borders, raster-order pixel stream
// pix channel: one word per pixel (req_type 0) or a drain word (req_type 1);
//   drain words flush the last rows once the whole frame is in
// res channel: at most one filtered pixel per pix word, raster order,
//   frame_end marks the last pixel of the frame; unused channels read 0
// cfg channel: cfg_index selects a register, cfg_data is the value; always
//   ready, write only while the block is idle
// sequence: a pixel word is taken, the row pass writes its columns (at most
//   one column, or up to r+1 at the end of a row), a ready check follows,
//   and the column pass runs when a result is due; the shared
//   multiply-accumulate unit does one tap per cycle
// a new word is taken only in idle, once the last one is through; r = blur radius
// reset: counters clear, registers take their defaults (1024x1024, 3
//   channels, radius 1, center tap 1.0); the row store needs no clearing
// a stalled receiver holds the result register; the next word is still
//   taken and worked, and the block waits only when a new result is due
module separable_gaussian_blur_unit #(
	parameter int MAX_WIDTH    = 1024,
	parameter int MAX_RADIUS   = 3,
	parameter int NUM_CHANNELS = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sgb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sgb_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               pix_valid,
	output logic                               pix_ready,
	input  logic                               req_type,
	input  logic [sgb_pkg::SAMPLE_W-1:0]       sample_a,
	input  logic [sgb_pkg::SAMPLE_W-1:0]       sample_b,
	input  logic [sgb_pkg::SAMPLE_W-1:0]       sample_c,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic [sgb_pkg::SAMPLE_W-1:0]       blurred_a,
	output logic [sgb_pkg::SAMPLE_W-1:0]       blurred_b,
	output logic [sgb_pkg::SAMPLE_W-1:0]       blurred_c,
	output logic                               frame_end
);
	import sgb_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WD     = 2 * MAX_RADIUS + 1;
	localparam int SLOT_W = $clog2(WD);
	localparam int LANES  = (NUM_CHANNELS < 3) ? NUM_CHANNELS : 3;
	localparam int DEPTH  = WD * MAX_WIDTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int DATA_W = LANES * SAMPLE_W;

	// configuration
	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic [1:0]       chans_q;
	logic [1:0]       rad_q;
	logic [TAP_W-1:0] taps_q [4];

	logic [COL_W-1:0] wm1;
	logic [ROW_W-1:0] hm1;
	logic [1:0]       r_eff;
	logic [1:0]       chans_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q      <= FW_W'(1024);
			fh_q      <= FH_W'(1024);
			chans_q   <= 2'd3;
			rad_q     <= 2'd1;
			taps_q[0] <= TAP_W'(32768);
			taps_q[1] <= '0;
			taps_q[2] <= '0;
			taps_q[3] <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_FRAME_WIDTH:   fw_q      <= cfg_data[FW_W-1:0];
				CFG_FRAME_HEIGHT:  fh_q      <= cfg_data[FH_W-1:0];
				CFG_CHANNEL_COUNT: chans_q   <= cfg_data[1:0];
				CFG_BLUR_RADIUS:   rad_q     <= cfg_data[1:0];
				CFG_TAP_CENTER:    taps_q[0] <= cfg_data;
				CFG_TAP_ONE:       taps_q[1] <= cfg_data;
				CFG_TAP_TWO:       taps_q[2] <= cfg_data;
				CFG_TAP_THREE:     taps_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (fw_q == '0) begin
			wm1 = '0;
		end else if (int'(fw_q) > MAX_WIDTH) begin
			wm1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			wm1 = COL_W'(fw_q - FW_W'(1));
		end
		if (fh_q == '0) begin
			hm1 = '0;
		end else if (fh_q[FH_W-1]) begin
			hm1 = '1;
		end else begin
			hm1 = ROW_W'(fh_q - FH_W'(1));
		end
		r_eff = (int'(rad_q) > MAX_RADIUS) ? 2'(MAX_RADIUS) : rad_q;
		if (chans_q == '0) begin
			chans_eff = 2'd1;
		end else if (int'(chans_q) > LANES) begin
			chans_eff = 2'(LANES);
		end else begin
			chans_eff = chans_q;
		end
	end

	// control state
	state_t               state_q, state_d;
	logic [COL_W-1:0]     in_col_q, out_col_q;
	logic [ROW_W-1:0]     in_row_q, out_row_q;
	logic [SLOT_W-1:0]    in_slot_q, out_slot_q, wslot_q;
	logic                 done_q;
	logic [COL_W-1:0]     c_q, j_q, jlast_q;
	logic [TAP_CNT_W-1:0] t_q;
	logic                 rd_vld_s1;
	logic [1:0]           wsel_s1;
	logic [LANES-1:0][SAMPLE_W-1:0] win_q [WD];

	logic                 res_valid_q, frame_end_q;
	logic [2:0][SAMPLE_W-1:0] res_q;

	// handshake and pixel decode
	logic pix_fire, take_pix, last_tap, emit_go, rdy;
	logic [COL_W-1:0] c_now, j_start, j_last;
	logic row_end, has_col;
	logic [LANES-1:0][SAMPLE_W-1:0] pix_in;
	logic [2:0][SAMPLE_W-1:0] samp_all;

	assign pix_fire = pix_valid & pix_ready;
	assign take_pix = pix_fire & ~req_type & ~done_q;
	assign last_tap = (t_q == {r_eff, 1'b0});
	assign samp_all = {sample_c, sample_b, sample_a};

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			pix_in[i] = samp_all[i];
		end
		c_now   = (in_col_q > wm1) ? wm1 : in_col_q;
		row_end = (c_now == wm1);
		has_col = row_end || (c_now >= COL_W'(r_eff));
		if (row_end && (c_now < COL_W'(r_eff))) begin
			j_start = '0;
		end else begin
			j_start = c_now - COL_W'(r_eff);
		end
		j_last = row_end ? c_now : c_now - COL_W'(r_eff);
	end

	// row pass tap
	logic signed [3:0]       d_tap;
	logic [1:0]              abs_d;
	logic signed [COL_W+1:0] pos_raw;
	logic [COL_W-1:0]        pos, k_full;
	logic [SLOT_W-1:0]       k_idx;

	always_comb begin
		d_tap   = signed'({1'b0, t_q}) - signed'({2'b00, r_eff});
		abs_d   = (d_tap < 0) ? 2'(-d_tap) : 2'(d_tap);
		pos_raw = signed'({2'b00, j_q}) + (COL_W+2)'(d_tap);
		if (pos_raw < 0) begin
			pos = '0;
		end else if (pos_raw > signed'({2'b00, c_q})) begin
			pos = c_q;
		end else begin
			pos = pos_raw[COL_W-1:0];
		end
		k_full = c_q - pos;
		k_idx  = k_full[SLOT_W-1:0];
	end

	// column pass address
	logic signed [ROW_W+1:0] vr_raw;
	logic [ROW_W-1:0]        vrow;
	logic signed [ROW_W+1:0] off_full;
	logic signed [5:0]       slot_sum;
	logic [SLOT_W-1:0]       vslot;
	logic [ADDR_W-1:0]       raddr, waddr;
	logic [DATA_W-1:0]       rdata;

	always_comb begin
		vr_raw = signed'({2'b00, out_row_q}) + (ROW_W+2)'(d_tap);
		if (vr_raw < 0) begin
			vrow = '0;
		end else if (vr_raw > signed'({2'b00, hm1})) begin
			vrow = hm1;
		end else begin
			vrow = vr_raw[ROW_W-1:0];
		end
		off_full = signed'({2'b00, vrow}) - signed'({2'b00, out_row_q});
		slot_sum = signed'(6'(out_slot_q)) + 6'(off_full);
		if (slot_sum < 0) begin
			slot_sum = slot_sum + 6'(WD);
		end else if (slot_sum >= 6'(WD)) begin
			slot_sum = slot_sum - 6'(WD);
		end
		vslot = slot_sum[SLOT_W-1:0];
		raddr = ADDR_W'(vslot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(out_col_q);
		waddr = ADDR_W'(wslot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(j_q);
	end

	// ready check for the oldest pending result
	logic [ROW_W:0]   nr_sum;
	logic [ROW_W-1:0] nr;
	logic [COL_W:0]   nc_sum;
	logic [COL_W-1:0] nc;

	always_comb begin
		nr_sum = {1'b0, out_row_q} + (ROW_W+1)'(r_eff);
		nr     = (nr_sum > {1'b0, hm1}) ? hm1 : nr_sum[ROW_W-1:0];
		nc_sum = {1'b0, out_col_q} + (COL_W+1)'(r_eff);
		nc     = (nc_sum > {1'b0, wm1}) ? wm1 : nc_sum[COL_W-1:0];
		rdy    = done_q || (in_row_q > nr) || ((in_row_q == nr) && (in_col_q > nc));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (pix_fire) begin
					state_d = (take_pix && has_col) ? S_ROW : S_CHECK;
				end
			end
			S_ROW: begin
				if (last_tap && (j_q == jlast_q)) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: state_d = rdy ? S_VERT : S_IDLE;
			S_VERT: begin
				if (last_tap) begin
					state_d = S_VLAST;
				end
			end
			S_VLAST: state_d = S_EMIT;
			S_EMIT: begin
				if (!res_valid_q || res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the state machine
	mac_ctrl_t mac_ctrl;
	logic      ram_we;

	always_comb begin
		pix_ready    = 1'b0;
		mac_ctrl.clr = 1'b0;
		mac_ctrl.en  = rd_vld_s1;
		ram_we       = 1'b0;
		emit_go      = 1'b0;
		case (state_q)
			S_IDLE: begin
				pix_ready    = 1'b1;
				mac_ctrl.clr = pix_fire;
			end
			S_ROW: begin
				mac_ctrl.en  = 1'b1;
				mac_ctrl.clr = last_tap;
				ram_we       = last_tap;
			end
			S_CHECK: mac_ctrl.clr = 1'b1;
			S_EMIT:  emit_go = !res_valid_q || res_ready;
			default: ;
		endcase
	end

	// shared multiply-accumulate
	logic [TAP_W-1:0]               mac_w;
	logic [LANES-1:0][SAMPLE_W-1:0] mac_in, mac_sat;

	always_comb begin
		if (state_q == S_ROW) begin
			mac_w  = taps_q[abs_d];
			mac_in = win_q[k_idx];
		end else begin
			mac_w  = taps_q[wsel_s1];
			mac_in = rdata;
		end
	end

	sgb_mac #(
		.LANES(LANES)
	) u_mac (
		.clk     (clk),
		.ctrl    (mac_ctrl),
		.weight  (mac_w),
		.samples (mac_in),
		.sat     (mac_sat)
	);

	sgb_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_row_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (mac_sat),
		.raddr (raddr),
		.rdata (rdata)
	);

	// window of the newest pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WD; i++) begin
				win_q[i] <= '0;
			end
		end else if (take_pix) begin
			win_q[0] <= pix_in;
			for (int i = 1; i < WD; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

	// result word
	logic [2:0][SAMPLE_W-1:0] res_d;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res_d[i] = '0;
			if (i < LANES) begin
				if (2'(i) < chans_eff) begin
					res_d[i] = mac_sat[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			res_q       <= res_d;
			frame_end_q <= (out_col_q >= wm1) && (out_row_q >= hm1);
		end
	end

	assign res_valid = res_valid_q;
	assign blurred_a = res_q[0];
	assign blurred_b = res_q[1];
	assign blurred_c = res_q[2];
	assign frame_end = frame_end_q;

	// sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_slot_q   <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_slot_q  <= '0;
			done_q      <= 1'b0;
			c_q         <= '0;
			j_q         <= '0;
			jlast_q     <= '0;
			wslot_q     <= '0;
			t_q         <= '0;
			rd_vld_s1   <= 1'b0;
			wsel_s1     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == S_VERT);
			wsel_s1   <= abs_d;

			if (take_pix) begin
				c_q     <= c_now;
				j_q     <= j_start;
				jlast_q <= j_last;
				wslot_q <= in_slot_q;
				if (in_col_q >= wm1) begin
					in_col_q <= '0;
					if (in_row_q >= hm1) begin
						in_row_q  <= '0;
						in_slot_q <= '0;
						done_q    <= 1'b1;
					end else begin
						in_row_q  <= in_row_q + ROW_W'(1);
						in_slot_q <= (int'(in_slot_q) == WD - 1) ? '0 :
							in_slot_q + SLOT_W'(1);
					end
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end

			case (state_q)
				S_IDLE, S_CHECK: t_q <= '0;
				S_ROW: begin
					if (last_tap) begin
						t_q <= '0;
						j_q <= j_q + COL_W'(1);
					end else begin
						t_q <= t_q + TAP_CNT_W'(1);
					end
				end
				S_VERT: t_q <= t_q + TAP_CNT_W'(1);
				default: ;
			endcase

			if (emit_go) begin
				res_valid_q <= 1'b1;
				if (out_col_q >= wm1) begin
					out_col_q <= '0;
					if (out_row_q >= hm1) begin
						out_row_q  <= '0;
						out_slot_q <= '0;
						done_q     <= 1'b0;
					end else begin
						out_row_q  <= out_row_q + ROW_W'(1);
						out_slot_q <= (int'(out_slot_q) == WD - 1) ? '0 :
							out_slot_q + SLOT_W'(1);
					end
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- tb/blur_checker.sv -----
`timescale 1ns / 100ps

module blur_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [sgb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sgb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           pix_valid,
	input  logic                           pix_ready,
	input  logic                           req_type,
	input  logic [sgb_pkg::SAMPLE_W-1:0]   sample_a,
	input  logic [sgb_pkg::SAMPLE_W-1:0]   sample_b,
	input  logic [sgb_pkg::SAMPLE_W-1:0]   sample_c,
	input  logic                           res_valid,
	input  logic                           res_ready,
	input  logic [sgb_pkg::SAMPLE_W-1:0]   blurred_a,
	input  logic [sgb_pkg::SAMPLE_W-1:0]   blurred_b,
	input  logic [sgb_pkg::SAMPLE_W-1:0]   blurred_c,
	input  logic                           frame_end,
	output int                             errors,
	output int                             pending,
	output int                             frame_left
);
	import sgb_pkg::*;

	localparam int DEPTH = 7;
	localparam int WMAX  = 1024;

	typedef struct {
		logic [7:0] px [0:2];
		logic       last;
	} blur_word_t;

	logic [FW_W-1:0] fw;
	logic [FH_W-1:0] fh;
	logic [1:0]      chans_reg;
	logic [1:0]      rad_reg;
	logic [15:0]     taps [0:3];

	logic [7:0] win [0:DEPTH-1][0:2];
	logic [7:0] row_mem [0:DEPTH*WMAX-1][0:2];
	int in_row, in_col, out_row, out_col, emitted;
	bit in_done;

	blur_word_t blurred_q [$];

	function automatic int eff_w();
		return fw < 1 ? 1 : (fw > WMAX ? WMAX : int'(fw));
	endfunction

	function automatic int eff_h();
		return fh < 1 ? 1 : (fh > 4096 ? 4096 : int'(fh));
	endfunction

	function automatic int clip(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic [7:0] trunc_clamp(longint unsigned acc);
		longint unsigned v;
		v = acc >> 15;
		return v > 255 ? 8'hff : v[7:0];
	endfunction

	task automatic filter_row(int j, int c, int w, int r, int slot);
		longint unsigned acc;
		int k;
		for (int ch = 0; ch < 3; ch++) begin
			acc = 0;
			for (int d = -r; d <= r; d++) begin
				k = c - clip(j + d, 0, w - 1);
				if (k >= 0 && k < DEPTH)
					acc += taps[d < 0 ? -d : d] * win[k][ch];
			end
			row_mem[slot * WMAX + j][ch] = trunc_clamp(acc);
		end
	endtask

	task automatic take_word(logic drain, logic [7:0] sa, logic [7:0] sb, logic [7:0] sc);
		int w, h, r, nch, c, slot, orow, oc, nr, nc;
		longint unsigned acc;
		bit ready;
		blur_word_t e;
		w = eff_w();
		h = eff_h();
		r = rad_reg;
		nch = chans_reg < 1 ? 1 : chans_reg;
		if (!drain && !in_done) begin
			c = in_col < w ? in_col : w - 1;
			slot = in_row % DEPTH;
			for (int k = DEPTH - 1; k > 0; k--)
				for (int ch = 0; ch < 3; ch++)
					win[k][ch] = win[k-1][ch];
			win[0][0] = sa;
			win[0][1] = sb;
			win[0][2] = sc;
			if (c == w - 1) begin
				for (int j = (c - r < 0 ? 0 : c - r); j <= c; j++)
					filter_row(j, c, w, r, slot);
			end else if (c - r >= 0) begin
				filter_row(c - r, c, w, r, slot);
			end
			if (in_col >= w - 1) begin
				in_col = 0;
				if (in_row >= h - 1) begin
					in_row = 0;
					in_done = 1;
				end else begin
					in_row++;
				end
			end else begin
				in_col++;
			end
		end
		orow = out_row < h ? out_row : h - 1;
		oc = out_col < w ? out_col : w - 1;
		nr = orow + r < h - 1 ? orow + r : h - 1;
		nc = oc + r < w - 1 ? oc + r : w - 1;
		ready = in_done || in_row > nr || (in_row == nr && in_col > nc);
		if (ready) begin
			for (int ch = 0; ch < 3; ch++) begin
				acc = 0;
				if (ch < nch)
					for (int d = -r; d <= r; d++)
						acc += taps[d < 0 ? -d : d] *
							row_mem[(clip(orow + d, 0, h - 1) % DEPTH) * WMAX + oc][ch];
				e.px[ch] = ch < nch ? trunc_clamp(acc) : 8'h00;
			end
			e.last = 0;
			emitted++;
			if (out_col >= w - 1) begin
				out_col = 0;
				if (out_row >= h - 1) begin
					out_row = 0;
					in_done = 0;
					e.last = 1;
					emitted = 0;
				end else begin
					out_row++;
				end
			end else begin
				out_col++;
			end
			blurred_q.push_back(e);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		blur_word_t e;
		if (!arst_n) begin
			fw = 11'd1024;
			fh = 13'd1024;
			chans_reg = 2'd3;
			rad_reg = 2'd1;
			taps[0] = 16'd32768;
			taps[1] = 16'd0;
			taps[2] = 16'd0;
			taps[3] = 16'd0;
			for (int k = 0; k < DEPTH; k++)
				for (int ch = 0; ch < 3; ch++)
					win[k][ch] = 8'h00;
			in_row = 0;
			in_col = 0;
			out_row = 0;
			out_col = 0;
			emitted = 0;
			in_done = 0;
			errors = 0;
			blurred_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_FRAME_WIDTH: fw = cfg_data[FW_W-1:0];
					CFG_FRAME_HEIGHT: fh = cfg_data[FH_W-1:0];
					CFG_CHANNEL_COUNT: chans_reg = cfg_data[1:0];
					CFG_BLUR_RADIUS: rad_reg = cfg_data[1:0];
					CFG_TAP_CENTER: taps[0] = cfg_data;
					CFG_TAP_ONE: taps[1] = cfg_data;
					CFG_TAP_TWO: taps[2] = cfg_data;
					CFG_TAP_THREE: taps[3] = cfg_data;
					default: ;
				endcase
			end
			if (pix_valid && pix_ready)
				take_word(req_type, sample_a, sample_b, sample_c);
			if (res_valid && res_ready) begin
				if (blurred_q.size() == 0) begin
					$error("unexpected result word");
					errors++;
				end else begin
					e = blurred_q.pop_front();
					if (blurred_a !== e.px[0]) begin
						$error("blurred_a expected %0d actual %0d", e.px[0], blurred_a);
						errors++;
					end
					if (blurred_b !== e.px[1]) begin
						$error("blurred_b expected %0d actual %0d", e.px[1], blurred_b);
						errors++;
					end
					if (blurred_c !== e.px[2]) begin
						$error("blurred_c expected %0d actual %0d", e.px[2], blurred_c);
						errors++;
					end
					if (frame_end !== e.last) begin
						$error("frame_end expected %0d actual %0d", e.last, frame_end);
						errors++;
					end
				end
			end
		end
		pending = blurred_q.size();
		frame_left = eff_w() * eff_h() - emitted;
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import sgb_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  pix_valid;
	logic                  pix_ready;
	logic                  req_type;
	logic [SAMPLE_W-1:0]   sample_a;
	logic [SAMPLE_W-1:0]   sample_b;
	logic [SAMPLE_W-1:0]   sample_c;
	logic                  res_valid;
	logic                  res_ready;
	logic [SAMPLE_W-1:0]   blurred_a;
	logic [SAMPLE_W-1:0]   blurred_b;
	logic [SAMPLE_W-1:0]   blurred_c;
	logic                  frame_end;
	int errors, pending, frame_left;
	int words_sent, idle_cycles;
	bit no_gaps;

	separable_gaussian_blur_unit uut (.*);

	blur_checker blur_watch (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver stalls
	initial begin
		int hold;
		res_ready = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else if (no_gaps || $urandom_range(0, 3) != 0) begin
				res_ready <= 1;
			end else begin
				res_ready <= 0;
				hold = $urandom_range(0, 9) == 0 ? $urandom_range(10, 50) : $urandom_range(0, 2);
			end
		end
	end

	always @(posedge clk) begin
		if ((pix_valid && pix_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 3000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [7:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_word(logic drain);
		int gap;
		gap = no_gaps ? 0 :
			($urandom_range(0, 15) == 0 ? $urandom_range(8, 40) : $urandom_range(0, 1));
		if (gap > 0) begin
			pix_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1;
		req_type <= drain;
		sample_a <= rand_sample();
		sample_b <= rand_sample();
		sample_c <= rand_sample();
		do @(posedge clk); while (!pix_ready);
		words_sent++;
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic settle();
		pix_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic run_frame(int w, int h, int nch, int r, logic [15:0] t0, logic [15:0] t1,
			logic [15:0] t2, logic [15:0] t3);
		int ew, eh, n, strays;
		settle();
		write_reg(CFG_FRAME_WIDTH, 16'(w));
		write_reg(CFG_FRAME_HEIGHT, 16'(h));
		write_reg(CFG_CHANNEL_COUNT, 16'(nch));
		write_reg(CFG_BLUR_RADIUS, 16'(r));
		write_reg(CFG_TAP_CENTER, t0);
		write_reg(CFG_TAP_ONE, t1);
		write_reg(CFG_TAP_TWO, t2);
		write_reg(CFG_TAP_THREE, t3);
		cfg_valid <= 0;
		ew = w < 1 ? 1 : (w > 1024 ? 1024 : w);
		eh = h < 1 ? 1 : (h > 4096 ? 4096 : h);
		no_gaps = $urandom_range(0, 4) == 0;
		for (int i = 0; i < ew * eh; i++) begin
			if ($urandom_range(0, 11) == 0)
				send_word(1);
			send_word(0);
		end
		pix_valid <= 0;
		@(posedge clk);
		// words after the last pixel, stray pixels first
		n = frame_left;
		strays = $urandom_range(0, n < 3 ? n : 3);
		for (int i = 0; i < strays; i++)
			send_word(0);
		for (int i = strays; i < n + $urandom_range(0, 2); i++)
			send_word(1);
	endtask

	function automatic logic [15:0] rand_tap();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'd32768;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 16384));
		endcase
	endfunction

	initial begin
		int r;
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data = 0;
		pix_valid = 0;
		req_type = 0;
		sample_a = 0;
		sample_b = 0;
		sample_c = 0;
		words_sent = 0;
		idle_cycles = 0;
		no_gaps = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// drain with nothing ready
		send_word(1);
		run_frame(1, 1, 3, 0, 16'd32768, 16'd0, 16'd0, 16'd0);
		run_frame(3, 3, 3, 3, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		run_frame(0, 0, 0, 2, 16'd16384, 16'd8192, 16'd0, 16'd0);
		run_frame(4, 2, 2, 1, 16'd16384, 16'd8192, 16'd0, 16'd0);
		run_frame(2, 3, 1, 3, 16'd9000, 16'd7000, 16'd4000, 16'd1500);
		while (words_sent < 150) begin
			r = $urandom_range(0, 3);
			run_frame($urandom_range(1, 10), $urandom_range(1, 8), $urandom_range(0, 3), r,
				rand_tap(), rand_tap(), rand_tap(), rand_tap());
		end
		// oversized width clamps to the limit
		run_frame(2047, 1, 3, 3, rand_tap(), rand_tap(), rand_tap(), rand_tap());
		settle();
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
